@@ rtl/sdc_pkg.sv @@
// Shared types, widths and constants of the straight-drive controller.
// Used by sdc_div and straight_drive_controller; depends on nothing.
`default_nettype none

package sdc_pkg;

  // Encoder sample width, signed degrees
  localparam int POSITION_BITS = 21;

  localparam int TARGET_W = 20;
  localparam int CAP_W    = 7;
  localparam int GAIN_W   = 12;
  localparam int SPEED_W  = 16;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 20;

  localparam logic [CFG_INDEX_W-1:0] REG_TARGET  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_REVERSE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CAP     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN    = 2'd3;

  localparam logic [TARGET_W-1:0] TARGET_RESET = '0;
  localparam logic [CAP_W-1:0]    CAP_RESET    = 7'd100;
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 12'd256;

  // Datapath widths
  localparam int MAG_W      = POSITION_BITS;
  localparam int ERR_BASE_W = (POSITION_BITS > TARGET_W) ? POSITION_BITS : TARGET_W;
  localparam int ERR_W      = ERR_BASE_W + 3;
  localparam int EMAG_W     = ERR_BASE_W + 2;
  localparam int PROD_W     = EMAG_W + GAIN_W;
  // Quotient bits: scaled speed never exceeds cap * 256
  localparam int Q_W        = CAP_W + 8;
  localparam int NUM_W      = PROD_W + CAP_W;
  localparam int FRAC_SHIFT = Q_W - 8;
  localparam int DIV_STAGES = Q_W;

  // Gain has 8 fraction bits and speeds carry 8: raw speed is product / 8
  localparam int RAW_SHIFT = 3;
  // Scaling threshold is cap * 2048
  localparam int CAP_THR_SHIFT = 11;

  localparam int TILT_LIMIT    = 10;
  localparam int ERR_SUM_LIMIT = 36;
  localparam logic signed [ERR_W-1:0] TILT_LIM_S = ERR_W'(TILT_LIMIT);
  localparam logic [EMAG_W:0]         ERR_SUM_LIM = (EMAG_W + 1)'(ERR_SUM_LIMIT);

  // Stream payload widths, padded to whole bytes
  localparam int S_TDATA_W = ((2 * POSITION_BITS + 7) / 8) * 8;
  localparam int M_TDATA_W = ((2 * SPEED_W + 1 + 7) / 8) * 8;

  // Per-item information that rides alongside the divider
  typedef struct packed {
    logic           use_q_l;
    logic           use_q_r;
    logic [Q_W-1:0] mag_l;
    logic [Q_W-1:0] mag_r;
    logic           neg_l;
    logic           neg_r;
    logic           arrived;
  } sdc_side_t;

  // One divider stage: partial remainder, divisor, dividend bits still to
  // shift in, quotient so far, and the sideband
  typedef struct packed {
    logic [PROD_W-1:0] rem;
    logic [PROD_W-1:0] dvs;
    logic [Q_W-1:0]    lo;
    logic [Q_W-1:0]    quo;
    sdc_side_t         side;
  } sdc_div_t;

endpackage

`default_nettype wire

@@ rtl/sdc_div.sv @@
// Pipelined restoring divider for the speed scaling, one quotient bit per stage.
// Depends on sdc_pkg (sdc_div_t, widths).
`default_nettype none

module sdc_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sdc_pkg::sdc_div_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sdc_pkg::sdc_div_t out_data
);
  import sdc_pkg::*;

  logic [DIV_STAGES-1:0] vld;
  logic [DIV_STAGES:0]   rdy;
  sdc_div_t              stg [DIV_STAGES];

  // Shift in one dividend bit, subtract the divisor when it fits
  function automatic sdc_div_t div_step(input sdc_div_t a);
    sdc_div_t        b;
    logic [PROD_W:0] trial;
    logic [PROD_W:0] dvs_x;
    b     = a;
    trial = {a.rem, a.lo[Q_W-1]};
    dvs_x = {1'b0, a.dvs};
    b.lo  = {a.lo[Q_W-2:0], 1'b0};
    if (trial >= dvs_x) begin
      b.rem = PROD_W'(trial - dvs_x);
      b.quo = {a.quo[Q_W-2:0], 1'b1};
    end else begin
      b.rem = trial[PROD_W-1:0];
      b.quo = {a.quo[Q_W-2:0], 1'b0};
    end
    return b;
  endfunction

  assign rdy[DIV_STAGES] = out_ready;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    sdc_div_t src;
    logic     src_v;

    if (k == 0) begin : g_first
      assign src   = in_data;
      assign src_v = in_valid;
    end else begin : g_rest
      assign src   = stg[k-1];
      assign src_v = vld[k-1];
    end

    // Advance when this stage is empty or its content moves on
    assign rdy[k] = !vld[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && src_v) begin
        stg[k] <= div_step(src);
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[DIV_STAGES-1];
  assign out_data  = stg[DIV_STAGES-1];

endmodule

`default_nettype wire

@@ rtl/straight_drive_controller.sv @@
// Straight-drive speed controller top level: config registers, front pipeline,
// divider pipeline and output register. Depends on sdc_pkg and sdc_div.
`default_nettype none

// Each request on the s_ stream carries one sample of the left and right
// encoder positions (signed degrees since the move began); each request on
// the m_ stream carries the two side speeds (Q8.8 percent) and the arrived
// flag for that sample, in order, one result per sample. The datapath is a
// fully pipelined chain of 22 register stages: six front stages (magnitudes,
// side errors, error magnitudes, gain multiply, max/scale decision, cap
// multiply), fifteen divider stages that each retire one quotient bit of
// the cap scaling, and the output register. Unless back-pressure from
// m_tready stalls the chain, a sample can enter every cycle, so throughput
// is one sample per clock. Every stage has its own valid bit and takes new
// data whenever it is empty or its content moves on, so the input keeps
// flowing into bubbles while a result waits on m_tready. The four registers
// (target, reverse, speed cap, gain) are written through cfg_wen/cfg_index/
// cfg_wdata and must only change while no sample is in flight.
module straight_drive_controller (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write port
  input  logic                            cfg_wen,
  input  logic [sdc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sdc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // Encoder samples
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // s_tdata, low bit up: left_position, right_position, zero pad
  input  logic [sdc_pkg::S_TDATA_W-1:0]   s_tdata,
  // Speed results
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata, low bit up: left_speed, right_speed, arrived, zero pad
  output logic [sdc_pkg::M_TDATA_W-1:0]   m_tdata
);
  import sdc_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [TARGET_W-1:0] target;
  logic                reverse;
  logic [CAP_W-1:0]    cap;
  logic [GAIN_W-1:0]   gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      target  <= TARGET_RESET;
      reverse <= 1'b0;
      cap     <= CAP_RESET;
      gain    <= GAIN_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_TARGET:  target  <= cfg_wdata[TARGET_W-1:0];
        REG_REVERSE: reverse <= cfg_wdata[0];
        REG_CAP:     cap     <= cfg_wdata[CAP_W-1:0];
        REG_GAIN:    gain    <= cfg_wdata[GAIN_W-1:0];
        default:     ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Stage handshake: a stage loads when it is empty or drains this cycle
  // ---------------------------------------------------------------------
  logic v1, v2, v3, v4, v5, v6;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy_out;
  logic div_in_ready, div_out_valid;
  sdc_div_t div_req, div_rsp;

  assign rdy_out = !m_tvalid || m_tready;
  assign rdy6    = !v6 || div_in_ready;
  assign rdy5    = !v5 || rdy6;
  assign rdy4    = !v4 || rdy5;
  assign rdy3    = !v3 || rdy4;
  assign rdy2    = !v2 || rdy3;
  assign rdy1    = !v1 || rdy2;
  assign s_tready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
      if (rdy6) v6 <= v5;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: position magnitudes
  // ---------------------------------------------------------------------
  logic signed [MAG_W-1:0] pos_l, pos_r;
  logic [MAG_W-1:0]        al1, ar1;

  assign pos_l = s_tdata[MAG_W-1:0];
  assign pos_r = s_tdata[2*MAG_W-1:MAG_W];

  always_ff @(posedge clk) begin
    if (rdy1 && s_tvalid) begin
      // Most negative sample wraps to 2^(MAG_W-1), correct as unsigned
      al1 <= pos_l[MAG_W-1] ? MAG_W'(-pos_l) : pos_l;
      ar1 <= pos_r[MAG_W-1] ? MAG_W'(-pos_r) : pos_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: tilt and side errors
  //   tilt = al - ar, el = t - al - tilt, er = t - ar + tilt
  // ---------------------------------------------------------------------
  logic signed [ERR_W-1:0] t_x, al_x, ar_x, tilt_c;
  logic signed [ERR_W-1:0] el2, er2;
  logic                    tilt_ok2;

  assign t_x    = ERR_W'(target);
  assign al_x   = ERR_W'(al1);
  assign ar_x   = ERR_W'(ar1);
  assign tilt_c = al_x - ar_x;

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      el2      <= t_x - al_x - tilt_c;
      er2      <= t_x - ar_x + tilt_c;
      // Signed compare: a large negative tilt passes this half
      tilt_ok2 <= tilt_c < TILT_LIM_S;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: error magnitudes, signs and the arrival test
  // ---------------------------------------------------------------------
  logic [EMAG_W-1:0] ml_c, mr_c;
  logic [EMAG_W:0]   err_sum;
  logic [EMAG_W-1:0] ml3, mr3;
  logic              negl3, negr3, arr3;

  assign ml_c    = el2[ERR_W-1] ? EMAG_W'(-el2) : EMAG_W'(el2);
  assign mr_c    = er2[ERR_W-1] ? EMAG_W'(-er2) : EMAG_W'(er2);
  assign err_sum = {1'b0, ml_c} + {1'b0, mr_c};

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      ml3   <= ml_c;
      mr3   <= mr_c;
      negl3 <= el2[ERR_W-1];
      negr3 <= er2[ERR_W-1];
      arr3  <= tilt_ok2 && (err_sum < ERR_SUM_LIM);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: gain products
  // ---------------------------------------------------------------------
  logic [PROD_W-1:0] pl4, pr4;
  logic              negl4, negr4, arr4;

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      pl4   <= PROD_W'(gain) * PROD_W'(ml3);
      pr4   <= PROD_W'(gain) * PROD_W'(mr3);
      negl4 <= negl3;
      negr4 <= negr3;
      arr4  <= arr3;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: pick the larger product and decide on scaling. The larger side
  // scales to exactly cap * 256; only the smaller one needs the divider.
  // Unscaled speeds are product / 8, which stays within cap * 256.
  // ---------------------------------------------------------------------
  logic              lmax;
  logic [PROD_W-1:0] mx_c, pmin_c, cap_thr;
  logic              scale_c;
  logic [Q_W-1:0]    cap_q;
  logic [PROD_W-1:0] mx5, pmin5;
  sdc_side_t         side5;

  assign lmax    = pl4 >= pr4;
  assign mx_c    = lmax ? pl4 : pr4;
  assign pmin_c  = lmax ? pr4 : pl4;
  assign cap_thr = PROD_W'(cap) << CAP_THR_SHIFT;
  assign scale_c = mx_c > cap_thr;
  assign cap_q   = {cap, 8'b0};

  always_ff @(posedge clk) begin
    if (rdy5 && v4) begin
      mx5           <= mx_c;
      pmin5         <= pmin_c;
      side5.use_q_l <= scale_c && !lmax;
      side5.use_q_r <= scale_c && lmax;
      side5.mag_l   <= scale_c ? cap_q : pl4[Q_W+RAW_SHIFT-1:RAW_SHIFT];
      side5.mag_r   <= scale_c ? cap_q : pr4[Q_W+RAW_SHIFT-1:RAW_SHIFT];
      side5.neg_l   <= negl4 ^ reverse;
      side5.neg_r   <= negr4 ^ reverse;
      side5.arrived <= arr4;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: numerator pmin * cap * 256 split for the divider. The
  // quotient is below 2^Q_W, so the top part is already below the divisor.
  // ---------------------------------------------------------------------
  logic [NUM_W-1:0] num_c;

  assign num_c = NUM_W'(pmin5) * NUM_W'(cap);

  always_ff @(posedge clk) begin
    if (rdy6 && v5) begin
      div_req.rem  <= num_c[NUM_W-1:FRAC_SHIFT];
      div_req.dvs  <= mx5;
      div_req.lo   <= {num_c[FRAC_SHIFT-1:0], 8'b0};
      div_req.quo  <= '0;
      div_req.side <= side5;
    end
  end

  // ---------------------------------------------------------------------
  // Divider pipeline
  // ---------------------------------------------------------------------
  sdc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v6),
    .in_ready (div_in_ready),
    .in_data  (div_req),
    .out_valid(div_out_valid),
    .out_ready(rdy_out),
    .out_data (div_rsp)
  );

  // ---------------------------------------------------------------------
  // Output register: choose quotient or fixed magnitude, apply sign
  // ---------------------------------------------------------------------
  logic [Q_W-1:0]     fin_ml, fin_mr;
  logic [SPEED_W-1:0] spd_l, spd_r;

  assign fin_ml = div_rsp.side.use_q_l ? div_rsp.quo : div_rsp.side.mag_l;
  assign fin_mr = div_rsp.side.use_q_r ? div_rsp.quo : div_rsp.side.mag_r;
  assign spd_l  = div_rsp.side.neg_l ? SPEED_W'(-{1'b0, fin_ml}) : SPEED_W'({1'b0, fin_ml});
  assign spd_r  = div_rsp.side.neg_r ? SPEED_W'(-{1'b0, fin_mr}) : SPEED_W'({1'b0, fin_mr});

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rdy_out) begin
      m_tvalid <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out && div_out_valid) begin
      m_tdata <= M_TDATA_W'({div_rsp.side.arrived, spd_r, spd_l});
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  logic [SPEED_W-1:0] chk_l, chk_r, chk_lim;

  assign chk_l   = m_tdata[SPEED_W-1] ? SPEED_W'(-m_tdata[SPEED_W-1:0])
                                      : m_tdata[SPEED_W-1:0];
  assign chk_r   = m_tdata[2*SPEED_W-1] ? SPEED_W'(-m_tdata[2*SPEED_W-1:SPEED_W])
                                        : m_tdata[2*SPEED_W-1:SPEED_W];
  assign chk_lim = SPEED_W'(cap_q);

  // A free output slot frees the whole pipeline
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    rdy_out |-> s_tready)
    else $error("input stalled while output slot is free");

  // Scaling never lets a side exceed cap * 256
  a_speed_cap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (chk_l <= chk_lim) && (chk_r <= chk_lim))
    else $error("speed magnitude above cap");

  // A scaled result leaves a proper remainder behind
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (div_out_valid && (div_rsp.side.use_q_l || div_rsp.side.use_q_r))
      |-> (div_rsp.rem < div_rsp.dvs))
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire
